FILE: sv/smf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package smf_pkg;

   // Request command codes.
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_EVENT = 2'd2;

   // UART register offsets with special behavior.
   localparam logic [2:0] PORT_RX  = 3'd0;
   localparam logic [2:0] PORT_MCR = 3'd4;
   localparam logic [2:0] PORT_LSR = 3'd5;

   localparam int REG_COUNT = 8;

   localparam logic [7:0] MCR_MASK   = 8'h03;
   localparam logic [7:0] LSR_BASE   = 8'h60;
   localparam logic [7:0] LSR_DR     = 8'h01;
   localparam logic [7:0] ID_BYTE    = 8'h4D;
   localparam logic [1:0] PKT_SYNC   = 2'b01;

   localparam int DEFAULT_FIFO_DEPTH = 16;

   // Push sequencing: six identification bytes or a three-byte mouse packet.
   localparam int IDX_W = 3;
   localparam logic [IDX_W-1:0] ID_LAST    = 3'd5;
   localparam logic [IDX_W-1:0] EVENT_LAST = 3'd2;
   localparam logic [IDX_W-1:0] PKT_HEAD   = 3'd0;
   localparam logic [IDX_W-1:0] PKT_X      = 3'd1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             capture;
      logic             exec;
      logic             push;
      logic [IDX_W-1:0] push_idx;
      logic             pop_take;
      logic             load_out;
   } smf_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic push_id;
      logic pop;
      logic is_event;
   } smf_status_type;

endpackage

`default_nettype wire

FILE: sv/serial_mouse_uart_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    Direction  Handshake              Payload
// request    in         req_valid / req_stall  req_cmd, req_port, req_write_data,
//                                              req_buttons, req_move_x, req_move_y
// response   out        rsp_valid / rsp_stall  rsp_read_data, rsp_irq
//
// One request is worked on at a time. A port write or a register read goes
// through capture, execute and done; a pop from the receive port adds a pop
// wait, and a mouse event or a modem control write that changes DTR or RTS
// adds the push sequence. Pushes into the receive FIFO go one byte per cycle
// through its single write port; a pop waits for the registered memory read.
// Reset clears the register file, FIFO head and FIFO count; contents need none.
// A stalled response stays in the output register while the next request
// is taken; only the finish of that request waits for the register to free.

module serial_mouse_uart_fifo #(
   parameter int FIFO_DEPTH = smf_pkg::DEFAULT_FIFO_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_cmd,
   input  wire logic [2:0]        req_port,
   input  wire logic [7:0]        req_write_data,
   input  wire logic [1:0]        req_buttons,
   input  wire logic signed [7:0] req_move_x,
   input  wire logic signed [7:0] req_move_y,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [7:0]             rsp_read_data,
   output logic                   rsp_irq
);
   import smf_pkg::*;

   // The controller steps each request through capture, execute, the push
   // sequence or the pop wait, and the hand-off into the response register.
   smf_cmd_type    cmd;
   smf_status_type st;

   smf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .st        (st),
      .cmd       (cmd)
   );

   // The datapath holds the UART registers, the circular receive FIFO and
   // the response register.
   smf_dp #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .st             (st),
      .req_cmd        (req_cmd),
      .req_port       (req_port),
      .req_write_data (req_write_data),
      .req_buttons    (req_buttons),
      .req_move_x     (req_move_x),
      .req_move_y     (req_move_y),
      .rsp_read_data  (rsp_read_data),
      .rsp_irq        (rsp_irq)
   );

endmodule

`default_nettype wire

FILE: sv/smf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module smf_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire smf_pkg::smf_status_type st,
   output smf_pkg::smf_cmd_type        cmd
);
   import smf_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_PUSH = 3'd2;
   localparam logic [2:0] ST_POP  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             event_ff, event_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] last_idx;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign last_idx  = event_ff ? EVENT_LAST : ID_LAST;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      event_in     = event_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.push_idx = idx_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            idx_in   = '0;
            event_in = st.is_event;
            if (st.push_id || st.is_event) begin
               state_in = ST_PUSH;
            end else if (st.pop) begin
               state_in = ST_POP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            if (idx_ff == last_idx) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_POP: begin
            cmd.pop_take = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         event_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         event_ff     <= event_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/smf_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module smf_dp #(
   parameter int FIFO_DEPTH = smf_pkg::DEFAULT_FIFO_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire smf_pkg::smf_cmd_type  cmd,
   output smf_pkg::smf_status_type    st,
   input  wire logic [1:0]            req_cmd,
   input  wire logic [2:0]            req_port,
   input  wire logic [7:0]            req_write_data,
   input  wire logic [1:0]            req_buttons,
   input  wire logic signed [7:0]     req_move_x,
   input  wire logic signed [7:0]     req_move_y,
   output logic [7:0]                 rsp_read_data,
   output logic                       rsp_irq
);
   import smf_pkg::*;

   localparam int PW = $clog2(FIFO_DEPTH);
   localparam int CW = $clog2(FIFO_DEPTH + 1);
   localparam int SW = PW + 1;
   localparam logic [SW-1:0] DEPTH_S = SW'(FIFO_DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);

   // Captured request.
   logic [1:0]        cmd_ff, cmd_in;
   logic [2:0]        port_ff, port_in;
   logic [7:0]        wdata_ff, wdata_in;
   logic [1:0]        btn_ff, btn_in;
   logic [7:0]        mx_ff, mx_in;
   logic [7:0]        my_ff, my_in;

   logic [7:0]        reg_file_ff [REG_COUNT];
   logic [7:0]        reg_file_in [REG_COUNT];

   logic [PW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [7:0]        rdata_ff, rdata_in;
   logic              irq_ff, irq_in;
   logic [7:0]        out_data_ff, out_data_in;
   logic              out_irq_ff, out_irq_in;

   logic [7:0]        fifo_mem [FIFO_DEPTH];
   logic [7:0]        rd_ff;

   logic [SW-1:0]     head_inc, wr_sum;
   logic [PW-1:0]     head_next, wr_addr;
   logic              full, empty, do_push;
   logic [7:0]        push_byte;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == DEPTH_C);
   assign do_push  = cmd.push && !full;

   assign head_inc  = {1'b0, head_ff} + SW'(1);
   assign head_next = (head_inc >= DEPTH_S) ? '0 : head_inc[PW-1:0];
   assign wr_sum    = {1'b0, head_ff} + SW'(count_ff);
   assign wr_addr   = (wr_sum >= DEPTH_S) ? PW'(wr_sum - DEPTH_S) : wr_sum[PW-1:0];

   always_comb begin
      if (cmd_ff == CMD_EVENT) begin
         case (cmd.push_idx)
            PKT_HEAD: push_byte = {PKT_SYNC, btn_ff, my_ff[7:6], mx_ff[7:6]};
            PKT_X:    push_byte = {2'b00, mx_ff[5:0]};
            default:  push_byte = {2'b00, my_ff[5:0]};
         endcase
      end else begin
         push_byte = ID_BYTE;
      end
   end

   always_comb begin
      st.push_id  = (cmd_ff == CMD_WRITE) && (port_ff == PORT_MCR) &&
                    (((wdata_ff ^ reg_file_ff[PORT_MCR]) & MCR_MASK) != '0);
      st.pop      = (cmd_ff == CMD_READ) && (port_ff == PORT_RX) && !empty;
      st.is_event = (cmd_ff == CMD_EVENT);
   end

   always_comb begin
      cmd_in      = cmd_ff;
      port_in     = port_ff;
      wdata_in    = wdata_ff;
      btn_in      = btn_ff;
      mx_in       = mx_ff;
      my_in       = my_ff;
      reg_file_in = reg_file_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      rdata_in    = rdata_ff;
      irq_in      = irq_ff;
      out_data_in = out_data_ff;
      out_irq_in  = out_irq_ff;

      if (cmd.capture) begin
         cmd_in   = req_cmd;
         port_in  = req_port;
         wdata_in = req_write_data;
         btn_in   = req_buttons;
         mx_in    = req_move_x;
         my_in    = req_move_y;
      end

      if (cmd.exec) begin
         irq_in   = 1'b0;
         rdata_in = '0;
         case (cmd_ff)
            CMD_WRITE: begin
               reg_file_in[port_ff] = wdata_ff;
               if (st.push_id) begin
                  count_in = '0;
               end
            end
            CMD_READ: begin
               if (port_ff == PORT_RX) begin
                  if (!empty) begin
                     head_in  = head_next;
                     count_in = count_ff - CW'(1);
                     irq_in   = (count_ff > CW'(1));
                  end
               end else if (port_ff == PORT_LSR) begin
                  rdata_in = empty ? LSR_BASE : (LSR_BASE | LSR_DR);
               end else begin
                  rdata_in = reg_file_ff[port_ff];
               end
            end
            default: begin
            end
         endcase
      end

      if (do_push) begin
         count_in = count_ff + CW'(1);
         if (empty) begin
            irq_in = 1'b1;
         end
      end

      if (cmd.pop_take) begin
         rdata_in = rd_ff;
      end

      if (cmd.load_out) begin
         out_data_in = rdata_ff;
         out_irq_in  = irq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         fifo_mem[wr_addr] <= push_byte;
      end
      rd_ff <= fifo_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      port_ff     <= port_in;
      wdata_ff    <= wdata_in;
      btn_ff      <= btn_in;
      mx_ff       <= mx_in;
      my_ff       <= my_in;
      rdata_ff    <= rdata_in;
      irq_ff      <= irq_in;
      out_data_ff <= out_data_in;
      out_irq_ff  <= out_irq_in;
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            reg_file_ff[i] <= '0;
         end
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         reg_file_ff <= reg_file_in;
         head_ff     <= head_in;
         count_ff    <= count_in;
      end
   end

   assign rsp_read_data = out_data_ff;
   assign rsp_irq       = out_irq_ff;

endmodule

`default_nettype wire
